### src/jsu_pkg.sv
// jsu_pkg: types, codes, character constants and the escape decode function for the json string unescape block
// no dependencies; imported by json_string_unescape_top and its testbench
`default_nettype none

package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] out_char;
		logic [2:0] error_code;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_OPENED = 2'd1,
		PH_BODY   = 2'd2,
		PH_ESC    = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_EMPTY   = 3'd1;
	localparam logic [2:0] ERR_NOQUOTE = 3'd2;
	localparam logic [2:0] ERR_LONE    = 3'd3;
	localparam logic [2:0] ERR_UNTERM  = 3'd4;
	localparam logic [2:0] ERR_ESCAPE  = 3'd5;
	localparam logic [2:0] ERR_LINE    = 3'd6;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	// escape letter to character; bit 8 set when the letter is a legal escape
	function automatic logic [8:0] decode_escape(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_APOS:   r = {1'b1, CH_APOS};
			CH_LOW_B:  r = {1'b1, CH_BS};
			CH_LOW_F:  r = {1'b1, CH_FF};
			CH_LOW_N:  r = {1'b1, CH_LF};
			CH_LOW_R:  r = {1'b1, CH_CR};
			CH_LOW_T:  r = {1'b1, CH_TAB};
			default:   r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### src/json_string_unescape_top.sv
// json_string_unescape_top: streaming decoder for one double-quoted json string
// depends on jsu_pkg for payload structs, phase enum, result and error codes
//
// usage:
//   req channel (req_valid / req_stall / req) carries one byte or an end marker per
//   transaction. rsp channel (rsp_valid / rsp_stall / rsp) carries a decoded
//   character, a finished status or an error code. a request gives zero or one
//   response; leading whitespace, the opening quote and an escape's backslash give none.
//   a request lands in an input register, is decoded against the phase register
//   and its response is loaded into the output register. one request per cycle is
//   taken while no response is held back by rsp_stall; the phase register update
//   is the only loop. when rsp_stall holds a waiting response, the input register
//   still drains requests that give no response; a request that gives one waits
//   there and req_stall rises, so at most two requests sit inside the block.
//   reset clears both registers' valid flags and returns the phase to idle,
//   waiting for leading whitespace or the opening quote.
`default_nettype none

module json_string_unescape_top import jsu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire in_item_t  req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output out_item_t      rsp
);

	logic      valid_s1;
	in_item_t  item_s1;
	phase_t    phase_q;
	logic      out_valid_q;
	out_item_t out_q;

	phase_t    phase_nxt;
	logic      has_res;
	out_item_t res;
	logic      advance;
	logic [8:0] esc;

	// decode of the item in the input register against the current phase
	always_comb begin
		phase_nxt = phase_q;
		has_res   = 1'b0;
		res       = '{result_kind: KIND_CHAR, out_char: 8'd0, error_code: ERR_NONE};
		esc       = decode_escape(item_s1.in_byte);
		case (phase_q)
			PH_IDLE: begin
				if (item_s1.end_of_input) begin
					has_res = 1'b1;
					res.result_kind = KIND_ERR;
					res.error_code  = ERR_EMPTY;
				end else if (item_s1.in_byte == CH_SPACE || item_s1.in_byte == CH_TAB ||
						item_s1.in_byte == CH_CR || item_s1.in_byte == CH_LF) begin
					phase_nxt = PH_IDLE;
				end else if (item_s1.in_byte == CH_QUOTE) begin
					phase_nxt = PH_OPENED;
				end else begin
					has_res = 1'b1;
					res.result_kind = KIND_ERR;
					res.error_code  = ERR_NOQUOTE;
				end
			end
			PH_OPENED, PH_BODY: begin
				if (item_s1.end_of_input) begin
					has_res = 1'b1;
					phase_nxt = PH_IDLE;
					res.result_kind = KIND_ERR;
					res.error_code  = (phase_q == PH_OPENED) ? ERR_LONE : ERR_UNTERM;
				end else if (item_s1.in_byte == CH_QUOTE) begin
					has_res = 1'b1;
					phase_nxt = PH_IDLE;
					res.result_kind = KIND_DONE;
				end else if (item_s1.in_byte == CH_BSLASH) begin
					phase_nxt = PH_ESC;
				end else if (item_s1.in_byte == CH_LF) begin
					has_res = 1'b1;
					phase_nxt = PH_IDLE;
					res.result_kind = KIND_ERR;
					res.error_code  = ERR_LINE;
				end else begin
					has_res = 1'b1;
					phase_nxt = PH_BODY;
					res.out_char = item_s1.in_byte;
				end
			end
			PH_ESC: begin
				has_res = 1'b1;
				if (item_s1.end_of_input) begin
					phase_nxt = PH_IDLE;
					res.result_kind = KIND_ERR;
					res.error_code  = ERR_UNTERM;
				end else if (!esc[8]) begin
					phase_nxt = PH_IDLE;
					res.result_kind = KIND_ERR;
					res.error_code  = ERR_ESCAPE;
				end else begin
					phase_nxt = PH_BODY;
					res.out_char = esc[7:0];
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
			end
		endcase
	end

	// the stage moves on when it has no response or the output register frees up
	assign advance   = valid_s1 && (!has_res || !out_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_nxt;
			end
			if (advance && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// a finished or error response always leaves the phase idle
	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res && res.result_kind != KIND_CHAR |=> phase_q == PH_IDLE)
		else $error("phase not idle after finished or error response");

	// while idle, the only response possible is an error
	a_idle_only_err: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_res && phase_q == PH_IDLE |-> res.result_kind == KIND_ERR)
		else $error("non-error response produced while idle");

	// input back-pressure only comes from a held response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && out_valid_q && rsp_stall)
		else $error("req_stall without a held response");

	// a new response appears only after a stage advance
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(advance && has_res))
		else $error("response appeared without a decoded transaction");

endmodule

`default_nettype wire

### sim/tb_json_string_unescape_top.sv
// tb_json_string_unescape_top: self-checking testbench for the json string unescape block
// depends on jsu_pkg and json_string_unescape_top; directed table, then random strings
`timescale 1ns / 100ps

module tb_json_string_unescape_top;
	import jsu_pkg::*;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t rsp;
	} stim_row_t;

	localparam out_item_t RSP_NONE = '0;
	localparam out_item_t RSP_DONE = '{KIND_DONE, 8'h00, ERR_NONE};
	localparam logic [7:0] CH_LOW_U = 8'h75;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_item_t  req_item;
	logic      rsp_valid;
	logic      rsp_stall;
	out_item_t rsp_item;

	stim_row_t cur_row;
	out_item_t pending_rsp[$];
	phase_t    dec_phase = PH_IDLE;
	int        err_count = 0;
	int        snd_idle_pct = 0;
	int        rcv_stall_pct = 0;
	int        hold_cycles = 0;

	logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_APOS, CH_LOW_B,
		CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};

	assign req_item = cur_row.item;

	json_string_unescape_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic in_item_t byte_in(input logic [7:0] c);
		return '{c, 1'b0};
	endfunction

	function automatic out_item_t err_rsp(input logic [2:0] code);
		return '{KIND_ERR, 8'h00, code};
	endfunction

	// decoder state update; returns 1 when the transaction yields a response
	function automatic bit unescape_step(input in_item_t it, output out_item_t r);
		logic [7:0] ch;
		bit         ok;
		r = RSP_NONE;
		case (dec_phase)
			PH_IDLE: begin
				if (it.end_of_input) begin
					r = err_rsp(ERR_EMPTY);
					return 1'b1;
				end
				if (it.in_byte == CH_SPACE || it.in_byte == CH_TAB ||
						it.in_byte == CH_CR || it.in_byte == CH_LF)
					return 1'b0;
				if (it.in_byte == CH_QUOTE) begin
					dec_phase = PH_OPENED;
					return 1'b0;
				end
				r = err_rsp(ERR_NOQUOTE);
				return 1'b1;
			end
			PH_OPENED, PH_BODY: begin
				if (it.end_of_input) begin
					r = err_rsp(dec_phase == PH_OPENED ? ERR_LONE : ERR_UNTERM);
					dec_phase = PH_IDLE;
					return 1'b1;
				end
				if (it.in_byte == CH_QUOTE) begin
					dec_phase = PH_IDLE;
					r = RSP_DONE;
					return 1'b1;
				end
				if (it.in_byte == CH_BSLASH) begin
					dec_phase = PH_ESC;
					return 1'b0;
				end
				if (it.in_byte == CH_LF) begin
					dec_phase = PH_IDLE;
					r = err_rsp(ERR_LINE);
					return 1'b1;
				end
				dec_phase = PH_BODY;
				r = '{KIND_CHAR, it.in_byte, ERR_NONE};
				return 1'b1;
			end
			default: begin
				dec_phase = PH_IDLE;
				if (it.end_of_input) begin
					r = err_rsp(ERR_UNTERM);
					return 1'b1;
				end
				ok = 1'b1;
				ch = it.in_byte;
				case (it.in_byte)
					CH_QUOTE, CH_BSLASH, CH_APOS: ch = it.in_byte;
					CH_LOW_B: ch = CH_BS;
					CH_LOW_F: ch = CH_FF;
					CH_LOW_N: ch = CH_LF;
					CH_LOW_R: ch = CH_CR;
					CH_LOW_T: ch = CH_TAB;
					default:  ok = 1'b0;
				endcase
				if (!ok) begin
					r = err_rsp(ERR_ESCAPE);
					return 1'b1;
				end
				dec_phase = PH_BODY;
				r = '{KIND_CHAR, ch, ERR_NONE};
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	// predict on accepted requests, check accepted responses
	always @(posedge clk) begin : scoreboard
		out_item_t exp;
		out_item_t want;
		bit        has;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				has = unescape_step(req_item, exp);
				if (cur_row.typed) begin
					has = 1'b1;
					exp = cur_row.rsp;
				end
				if (has)
					pending_rsp.push_back(exp);
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("response with no transaction outstanding");
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_item.result_kind !== want.result_kind)
						report_mismatch($sformatf("result_kind %0d, expected %0d",
							rsp_item.result_kind, want.result_kind));
					if (rsp_item.out_char !== want.out_char)
						report_mismatch($sformatf("out_char %02h, expected %02h",
							rsp_item.out_char, want.out_char));
					if (rsp_item.error_code !== want.error_code)
						report_mismatch($sformatf("error_code %0d, expected %0d",
							rsp_item.error_code, want.error_code));
				end
			end
		end
	end

	// response side back-pressure; a requested hold-off is counted down here
	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	task automatic send_row(input stim_row_t row);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cur_row <= row;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF);
		return c;
	endfunction

	// one string, mostly well formed, sometimes cut short, broken by a line feed or a bad escape, or plain noise
	task automatic build_string(ref in_item_t p[$]);
		int         sel;
		int         len;
		bit         hit;
		logic [7:0] c;
		p.delete();
		sel = $urandom_range(99);
		if (sel >= 92) begin
			repeat ($urandom_range(1, 4))
				p.push_back('{8'($urandom_range(255)), $urandom_range(3) == 0});
			p.push_back('{8'($urandom_range(255)), 1'b1});
			return;
		end
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(3))
				0: p.push_back(byte_in(CH_SPACE));
				1: p.push_back(byte_in(CH_TAB));
				2: p.push_back(byte_in(CH_CR));
				default: p.push_back(byte_in(CH_LF));
			endcase
		end
		p.push_back(byte_in(CH_QUOTE));
		len = ($urandom_range(15) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
		repeat (len) begin
			if ($urandom_range(3) == 0) begin
				p.push_back(byte_in(CH_BSLASH));
				p.push_back(byte_in(esc_letters[3'($urandom_range(7))]));
			end else begin
				p.push_back(byte_in(plain_byte()));
			end
		end
		if (sel < 80) begin
			p.push_back(byte_in(CH_QUOTE));
			return;
		end
		case ($urandom_range(3))
			0: p.push_back('{8'($urandom_range(255)), 1'b1});
			1: p.push_back(byte_in(CH_LF));
			2: begin
				p.push_back(byte_in(CH_BSLASH));
				p.push_back('{8'($urandom_range(255)), 1'b1});
			end
			default: begin
				// backslash with anything that is not an escape letter
				do begin
					c = 8'($urandom_range(255));
					hit = 1'b0;
					foreach (esc_letters[i])
						if (esc_letters[i] == c)
							hit = 1'b1;
				end while (hit);
				p.push_back(byte_in(CH_BSLASH));
				p.push_back(byte_in(c));
			end
		endcase
	endtask

	task automatic run_random(input int n_items);
		in_item_t str[$];
		int       sent;
		sent = 0;
		while (sent < n_items) begin
			build_string(str);
			foreach (str[i])
				send_row('{str[i], 1'b0, RSP_NONE});
			sent += str.size();
		end
		drain_responses();
	endtask

	initial begin : stimulus
		stim_row_t dir_rows[$];
		arst_n = 1'b0;
		req_valid = 1'b0;
		cur_row = '{'0, 1'b0, RSP_NONE};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows = '{
			'{'{8'hFF, 1'b1}, 1'b1, err_rsp(ERR_EMPTY)},
			'{byte_in(8'h00), 1'b1, err_rsp(ERR_NOQUOTE)},
			'{byte_in(8'hFF), 1'b1, err_rsp(ERR_NOQUOTE)},
			'{byte_in(CH_SPACE), 1'b0, RSP_NONE},
			'{byte_in(CH_TAB), 1'b0, RSP_NONE},
			'{byte_in(CH_CR), 1'b0, RSP_NONE},
			'{byte_in(CH_LF), 1'b0, RSP_NONE},
			'{byte_in(CH_QUOTE), 1'b0, RSP_NONE},
			'{'{8'h00, 1'b1}, 1'b1, err_rsp(ERR_LONE)},
			'{byte_in(CH_QUOTE), 1'b0, RSP_NONE},
			'{byte_in(8'hFF), 1'b0, RSP_NONE},
			'{byte_in(CH_BSLASH), 1'b0, RSP_NONE},
			'{byte_in(CH_LOW_U), 1'b1, err_rsp(ERR_ESCAPE)},
			'{byte_in(CH_QUOTE), 1'b0, RSP_NONE},
			'{byte_in(8'h00), 1'b0, RSP_NONE},
			'{byte_in(CH_LF), 1'b1, err_rsp(ERR_LINE)},
			'{byte_in(CH_QUOTE), 1'b0, RSP_NONE},
			'{byte_in(CH_BSLASH), 1'b0, RSP_NONE},
			'{'{8'h00, 1'b1}, 1'b1, err_rsp(ERR_UNTERM)},
			'{byte_in(CH_QUOTE), 1'b0, RSP_NONE},
			'{byte_in(CH_BSLASH), 1'b0, RSP_NONE},
			'{byte_in(CH_LOW_N), 1'b0, RSP_NONE},
			'{byte_in(CH_BSLASH), 1'b0, RSP_NONE},
			'{byte_in(CH_QUOTE), 1'b0, RSP_NONE},
			'{byte_in(CH_QUOTE), 1'b1, RSP_DONE}
		};
		foreach (dir_rows[i])
			send_row(dir_rows[i]);
		drain_responses();

		// full rate, with one long receiver hold-off so the block backs up
		hold_cycles = 300;
		run_random(420);

		snd_idle_pct = 81;
		rcv_stall_pct = 0;
		run_random(420);

		snd_idle_pct = 0;
		rcv_stall_pct = 81;
		run_random(420);

		snd_idle_pct = 19;
		rcv_stall_pct = 19;
		run_random(420);

		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_rsp.size() == 0)
			$display("json_string_unescape_top verification clean");
		else
			$display("json_string_unescape_top verification failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("json_string_unescape_top verification failed");
		$finish;
	end

endmodule
